// ===== hdl/perlin_noise_2d_macros.svh =====
// Assertion helpers for the noise block. Synthesis sees empty bodies.
`ifndef PERLIN_NOISE_2D_MACROS_SVH
`define PERLIN_NOISE_2D_MACROS_SVH
`ifndef SYNTHESIS
`define PN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`define PN_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("assertion failed");
`else
`define PN_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PN_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define PN_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== hdl/pn2d_pkg.sv =====
`default_nettype none
package pn2d_pkg;

	localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
	localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
	localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

	localparam longint SIN_C1 = 64'sd1686629713;
	localparam longint SIN_C3 = -64'sd693598668;
	localparam longint SIN_C5 = 64'sd85569306;
	localparam longint SIN_C7 = -64'sd5026995;
	localparam longint SIN_C9 = 64'sd172272;

	localparam int PIPE_DEPTH = 9;

	// Quarter-wave sine magnitude in Q1.15 for quarter index idx (0 .. 2^(angle_bits-2)).
	function automatic logic [15:0] sine_mag(input int idx, input int angle_bits);
		longint v;
		longint v30;
		longint w;
		longint acc;
		longint r;
		v = longint'(idx) <<< (18 - angle_bits);
		v30 = v * 64'sd16384;
		w = (v30 * v30) >>> 30;
		acc = SIN_C9;
		acc = SIN_C7 + ((acc * w) >>> 30);
		acc = SIN_C5 + ((acc * w) >>> 30);
		acc = SIN_C3 + ((acc * w) >>> 30);
		acc = SIN_C1 + ((acc * w) >>> 30);
		r = (((acc * v30) >>> 30) + 64'sd16384) >>> 15;
		if (r < 0) r = 0;
		if (r > 32767) r = 32767;
		return r[15:0];
	endfunction

	function automatic logic [31:0] rot16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

endpackage
`default_nettype wire

// ===== hdl/perlin_noise_2d.sv =====
`default_nettype none
// Two-dimensional gradient noise. Give a point (x_coord, y_coord) in signed fixed point
// with FRAC_BITS fraction bits by raising start for one cycle; busy never rises, so a new
// point may be issued on every clock. Each point passes through the nine register stages below;
// then done is high for exactly one cycle with its noise_value (signed Q1.15, saturated) on the
// port. Results come out in issue order, one per clock at full rate. The receiver
// cannot stall: sample noise_value whenever done is high.
// Stages: 1 cell corner and fraction; 2 x hash multiply; 3 y mix multiply; 4 final hash
// multiply and phase; 5 gradient lookup from the quarter-wave sine table; 6 gradient
// products; 7 dot sums with rounding; 8 blend along x; 9 blend along y and saturate.
// The quintic fade runs beside the hash, one Horner step per stage.
`include "perlin_noise_2d_macros.svh"
module perlin_noise_2d
	import pn2d_pkg::*;
#(
	parameter int FRAC_BITS  = 16,
	parameter int ANGLE_BITS = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] x_coord,
	input  wire logic signed [31:0] y_coord,
	output logic                    done,
	output logic signed [15:0]      noise_value
);

	localparam int QN  = 2 ** (ANGLE_BITS - 2);
	localparam int TSR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int TSL = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
	localparam logic signed [FRAC_BITS+17:0] RND = (FRAC_BITS+18)'(2 ** (FRAC_BITS - 1));

	// Quarter-wave table, folded to constants
	logic [15:0] qrom [QN+1];
	genvar gi;
	for (gi = 0; gi <= QN; gi++) begin : g_rom
		assign qrom[gi] = sine_mag(gi, ANGLE_BITS);
	end

	// Stage 1: cell corners, fractions, fade input
	logic                        v_s1;
	logic [31:0]                 x0_s1, x1_s1, y0_s1, y1_s1;
	logic [FRAC_BITS-1:0]        fx_s1, fy_s1;
	logic signed [17:0]          tx_s1, ty_s1;
	// Stage 2
	logic                        v_s2;
	logic [31:0]                 ax_s2 [2];
	logic [31:0]                 y0_s2, y1_s2;
	logic [FRAC_BITS-1:0]        fx_s2, fy_s2;
	logic signed [17:0]          tx_s2, ty_s2;
	logic signed [23:0]          fbx_s2, fby_s2;
	// Stage 3
	logic                        v_s3;
	logic [31:0]                 ax_s3 [2];
	logic [31:0]                 bh_s3 [4];
	logic [FRAC_BITS-1:0]        fx_s3, fy_s3;
	logic signed [17:0]          tx_s3, ty_s3;
	logic signed [23:0]          fcx_s3, fcy_s3;
	// Stage 4
	logic                        v_s4;
	logic [ANGLE_BITS-1:0]       ph_s4 [4];
	logic [FRAC_BITS-1:0]        fx_s4, fy_s4;
	logic signed [17:0]          tx_s4, ty_s4;
	logic signed [23:0]          fdx_s4, fdy_s4;
	// Stage 5
	logic                        v_s5;
	logic signed [15:0]          gx_s5 [4];
	logic signed [15:0]          gy_s5 [4];
	logic [FRAC_BITS-1:0]        fx_s5, fy_s5;
	logic signed [17:0]          wx_s5, wy_s5;
	// Stage 6
	logic                        v_s6;
	logic signed [FRAC_BITS+16:0] px_s6 [4];
	logic signed [FRAC_BITS+16:0] py_s6 [4];
	logic signed [17:0]          wx_s6, wy_s6;
	// Stage 7
	logic                        v_s7;
	logic signed [17:0]          dot_s7 [4];
	logic signed [17:0]          wx_s7, wy_s7;
	// Stage 8
	logic                        v_s8;
	logic signed [18:0]          r0_s8, r1_s8;
	logic signed [17:0]          wy_s8;

	assign busy = 1'b0;

	// Stage 1 combinational
	logic [31:0] tmpx, tmpy;
	always_comb begin
		tmpx = (32'(x_coord[FRAC_BITS-1:0]) >> TSR) << TSL;
		tmpy = (32'(y_coord[FRAC_BITS-1:0]) >> TSR) << TSL;
	end

	// Fade Horner steps, one multiply each
	logic signed [23:0] fax, fay;
	logic signed [47:0] fpx2, fpy2, fpx3, fpy3, fpx4, fpy4, fpx5, fpy5;
	always_comb begin
		fax  = 24'(tx_s1) * 24'sd6 - 24'sd983040;
		fay  = 24'(ty_s1) * 24'sd6 - 24'sd983040;
		fpx2 = fax * tx_s1;
		fpy2 = fay * ty_s1;
		fpx3 = fbx_s2 * tx_s2;
		fpy3 = fby_s2 * ty_s2;
		fpx4 = fcx_s3 * tx_s3;
		fpy4 = fcy_s3 * ty_s3;
		fpx5 = fdx_s4 * tx_s4;
		fpy5 = fdy_s4 * ty_s4;
	end

	// Hash mixing
	logic [31:0] bmix [4];
	logic [31:0] hfin [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			bmix[k] = (((k / 2) != 0 ? y1_s2 : y0_s2) ^ rot16(ax_s2[k % 2])) * HASH_MUL_B;
			hfin[k] = (ax_s3[k % 2] ^ rot16(bh_s3[k])) * HASH_MUL_C;
		end
	end

	// Gradient lookup: quarter index and sign from the top two phase bits
	logic [ANGLE_BITS-1:0] lph  [8];
	logic [ANGLE_BITS-3:0] llow [8];
	logic [ANGLE_BITS-2:0] lidx [8];
	logic signed [15:0]    lval [8];
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			lph[k]  = (k < 4) ? ph_s4[k % 4]
			                  : ph_s4[k % 4] + ANGLE_BITS'(QN);
			llow[k] = lph[k][ANGLE_BITS-3:0];
			lidx[k] = lph[k][ANGLE_BITS-2]
			        ? (ANGLE_BITS-1)'(QN) - (ANGLE_BITS-1)'(llow[k])
			        : (ANGLE_BITS-1)'(llow[k]);
			lval[k] = lph[k][ANGLE_BITS-1] ? -$signed(qrom[lidx[k]])
			                               : $signed(qrom[lidx[k]]);
		end
	end

	// Offsets: near corner is the fraction, far corner the fraction minus one
	logic signed [FRAC_BITS:0] dxv [4];
	logic signed [FRAC_BITS:0] dyv [4];
	logic signed [FRAC_BITS+17:0] dsum [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dxv[k]  = {((k % 2) != 0), fx_s5};
			dyv[k]  = {((k / 2) != 0), fy_s5};
			dsum[k] = (FRAC_BITS+18)'(px_s6[k]) + (FRAC_BITS+18)'(py_s6[k]) + RND;
		end
	end

	// Blends
	logic signed [18:0] dfa, dfb;
	logic signed [37:0] bpa, bpb;
	logic signed [19:0] dfy;
	logic signed [38:0] bpy;
	logic signed [19:0] rsum;
	always_comb begin
		dfa  = 19'(dot_s7[1]) - 19'(dot_s7[0]);
		dfb  = 19'(dot_s7[3]) - 19'(dot_s7[2]);
		bpa  = dfa * wx_s7;
		bpb  = dfb * wx_s7;
		dfy  = 20'(r1_s8) - 20'(r0_s8);
		bpy  = dfy * wy_s8;
		rsum = 20'(r0_s8) + 20'(bpy >>> 16);
	end

	// Valid chain: advance one stage per clock, never hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			done <= v_s8;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		// floor of the coordinate: arithmetic shift, never toward zero
		x0_s1 <= 32'(x_coord >>> FRAC_BITS);
		x1_s1 <= 32'(x_coord >>> FRAC_BITS) + 32'd1;
		y0_s1 <= 32'(y_coord >>> FRAC_BITS);
		y1_s1 <= 32'(y_coord >>> FRAC_BITS) + 32'd1;
		fx_s1 <= x_coord[FRAC_BITS-1:0];
		fy_s1 <= y_coord[FRAC_BITS-1:0];
		tx_s1 <= {2'b00, tmpx[15:0]};
		ty_s1 <= {2'b00, tmpy[15:0]};

		ax_s2[0] <= x0_s1 * HASH_MUL_A;
		ax_s2[1] <= x1_s1 * HASH_MUL_A;
		y0_s2    <= y0_s1;
		y1_s2    <= y1_s1;
		fx_s2    <= fx_s1;
		fy_s2    <= fy_s1;
		tx_s2    <= tx_s1;
		ty_s2    <= ty_s1;
		fbx_s2   <= 24'(fpx2 >>> 16) + 24'sd655360;
		fby_s2   <= 24'(fpy2 >>> 16) + 24'sd655360;

		ax_s3  <= ax_s2;
		bh_s3  <= bmix;
		fx_s3  <= fx_s2;
		fy_s3  <= fy_s2;
		tx_s3  <= tx_s2;
		ty_s3  <= ty_s2;
		fcx_s3 <= 24'(fpx3 >>> 16);
		fcy_s3 <= 24'(fpy3 >>> 16);

		for (int k = 0; k < 4; k++) begin
			ph_s4[k] <= hfin[k][31 -: ANGLE_BITS];
		end
		fx_s4  <= fx_s3;
		fy_s4  <= fy_s3;
		tx_s4  <= tx_s3;
		ty_s4  <= ty_s3;
		fdx_s4 <= 24'(fpx4 >>> 16);
		fdy_s4 <= 24'(fpy4 >>> 16);

		for (int k = 0; k < 4; k++) begin
			gx_s5[k] <= lval[k];
			gy_s5[k] <= lval[k+4];
		end
		fx_s5 <= fx_s4;
		fy_s5 <= fy_s4;
		wx_s5 <= 18'(fpx5 >>> 16);
		wy_s5 <= 18'(fpy5 >>> 16);

		for (int k = 0; k < 4; k++) begin
			px_s6[k] <= gx_s5[k] * dxv[k];
			py_s6[k] <= gy_s5[k] * dyv[k];
		end
		wx_s6 <= wx_s5;
		wy_s6 <= wy_s5;

		for (int k = 0; k < 4; k++) begin
			dot_s7[k] <= 18'(dsum[k] >>> FRAC_BITS);
		end
		wx_s7 <= wx_s6;
		wy_s7 <= wy_s6;

		r0_s8 <= 19'(dot_s7[0]) + 19'(bpa >>> 16);
		r1_s8 <= 19'(dot_s7[2]) + 19'(bpb >>> 16);
		wy_s8 <= wy_s7;

		// saturate to Q1.15
		if (rsum > 20'sd32767) begin
			noise_value <= 16'sh7fff;
		end else if (rsum < -20'sd32768) begin
			noise_value <= 16'sh8000;
		end else begin
			noise_value <= 16'(rsum);
		end
	end

	`PN_ASSERT_NEVER(a_never_busy, clk, arst_n, busy)
	`PN_ASSERT_NEXT(a_take_enters, clk, arst_n, start && !busy, v_s1)
	`PN_ASSERT_IMPL(a_done_latency, clk, arst_n, done, $past(start, PIPE_DEPTH))

endmodule
`default_nettype wire

// ===== sim/noise_checker.sv =====
module noise_checker #(
	parameter int FRAC_BITS  = 16,
	parameter int ANGLE_BITS = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic signed [31:0] x_coord,
	input  wire logic signed [31:0] y_coord,
	input  wire logic               done,
	input  wire logic signed [15:0] noise_value,
	output int                      fail_count,
	output int                      pending_count,
	output int                      result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import pn2d_pkg::HASH_MUL_A;
	import pn2d_pkg::HASH_MUL_B;
	import pn2d_pkg::HASH_MUL_C;

	localparam longint C1 = 64'sd1686629713;
	localparam longint C3 = -64'sd693598668;
	localparam longint C5 = 64'sd85569306;
	localparam longint C7 = -64'sd5026995;
	localparam longint C9 = 64'sd172272;
	localparam longint ONE16 = 64'sd65536;

	logic signed [15:0] expected_noise[$];

	function automatic longint fshr(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] swap_halves(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	function automatic logic [31:0] hash_phase(input logic [31:0] cx, input logic [31:0] cy);
		logic [31:0] a;
		logic [31:0] b;
		a = cx * HASH_MUL_A;
		b = cy ^ swap_halves(a);
		b = b * HASH_MUL_B;
		a = a ^ swap_halves(b);
		a = a * HASH_MUL_C;
		return a >> (32 - ANGLE_BITS);
	endfunction

	function automatic longint gradient_sine(input logic [31:0] phase);
		logic [1:0] quad;
		longint lo;
		longint u;
		longint v;
		longint v30;
		longint w;
		longint acc;
		longint r;
		quad = phase[ANGLE_BITS-1 -: 2];
		lo = longint'(phase & ((32'd1 << (ANGLE_BITS - 2)) - 1));
		u = lo <<< (18 - ANGLE_BITS);
		v = quad[0] ? ONE16 - u : u;
		v30 = v * 16384;
		w = fshr(v30 * v30, 30);
		acc = C9;
		acc = C7 + fshr(acc * w, 30);
		acc = C5 + fshr(acc * w, 30);
		acc = C3 + fshr(acc * w, 30);
		acc = C1 + fshr(acc * w, 30);
		r = fshr(fshr(acc * v30, 30) + 16384, 15);
		if (r < 0) r = 0;
		if (r > 32767) r = 32767;
		return quad[1] ? -r : r;
	endfunction

	function automatic longint corner_term(input logic [31:0] cx, input logic [31:0] cy,
			input longint dx, input longint dy);
		logic [31:0] p;
		logic [31:0] mask;
		longint gx;
		longint gy;
		mask = (32'd1 << ANGLE_BITS) - 1;
		p = hash_phase(cx, cy);
		gx = gradient_sine(p);
		gy = gradient_sine((p + (32'd1 << (ANGLE_BITS - 2))) & mask);
		return fshr(gx * dx + gy * dy + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
	endfunction

	function automatic longint quintic_fade(input logic [31:0] f);
		longint t;
		longint a;
		longint b;
		longint c;
		longint d;
		if (FRAC_BITS >= 16) t = longint'(f >> (FRAC_BITS - 16));
		else t = longint'(f) <<< (16 - FRAC_BITS);
		a = 6 * t - 15 * ONE16;
		b = fshr(a * t, 16) + 10 * ONE16;
		c = fshr(b * t, 16);
		d = fshr(c * t, 16);
		return fshr(d * t, 16);
	endfunction

	function automatic longint lerp16(input longint a0, input longint a1, input longint w);
		return a0 + fshr((a1 - a0) * w, 16);
	endfunction

	function automatic logic signed [15:0] predict_noise(input logic [31:0] ux,
			input logic [31:0] uy);
		logic [31:0] x0;
		logic [31:0] y0;
		logic [31:0] x1;
		logic [31:0] y1;
		logic [31:0] fmask;
		longint dx0;
		longint dy0;
		longint dx1;
		longint dy1;
		longint wx;
		longint wy;
		longint r0;
		longint r1;
		longint r;
		fmask = (32'd1 << FRAC_BITS) - 1;
		x0 = $signed(ux) >>> FRAC_BITS;
		y0 = $signed(uy) >>> FRAC_BITS;
		x1 = x0 + 1;
		y1 = y0 + 1;
		dx0 = longint'(ux & fmask);
		dy0 = longint'(uy & fmask);
		dx1 = dx0 - (64'sd1 <<< FRAC_BITS);
		dy1 = dy0 - (64'sd1 <<< FRAC_BITS);
		wx = quintic_fade(ux & fmask);
		wy = quintic_fade(uy & fmask);
		r0 = lerp16(corner_term(x0, y0, dx0, dy0), corner_term(x1, y0, dx1, dy0), wx);
		r1 = lerp16(corner_term(x0, y1, dx0, dy1), corner_term(x1, y1, dx1, dy1), wx);
		r = lerp16(r0, r1, wy);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		result_count = 0;
	end

	assign pending_count = expected_noise.size();

	// Sample at the rising edge; inputs change by NBA after it, so values are stable.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				result_count++;
				if (expected_noise.size() == 0)
					report_mismatch($sformatf("unexpected noise_value %0d", noise_value));
				else if (noise_value !== expected_noise[0]) begin
					report_mismatch($sformatf("noise_value %0d, expected %0d",
						noise_value, expected_noise[0]));
					void'(expected_noise.pop_front());
				end else
					void'(expected_noise.pop_front());
			end
			if (start && !busy)
				expected_noise.push_back(predict_noise(x_coord, y_coord));
		end
	end
endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BEATS = 1530;
	localparam int PIPE_LATENCY = 9;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;
	logic               done;
	logic signed [15:0] noise_value;
	int                 fail_count;
	int                 pending_count;
	int                 result_count;
	int                 beat_count;

	perlin_noise_2d dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_coord(x_coord), .y_coord(y_coord), .done(done), .noise_value(noise_value)
	);

	noise_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_coord(x_coord), .y_coord(y_coord), .done(done), .noise_value(noise_value),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Offer one point and hold it until the block takes the beat.
	// start stays high across back-to-back beats; it only drops on an idle cycle.
	task automatic send_point(input logic [31:0] px, input logic [31:0] py, input bit no_idle);
		while (!no_idle && $urandom_range(99) < 38) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		x_coord <= px;
		y_coord <= py;
		@(posedge clk);
		while (busy) @(posedge clk);
		beat_count++;
	endtask

	// Pick a coordinate: mostly near zero and cell edges, sometimes anywhere.
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(32'h0003_ffff);
			2: return -$urandom_range(32'h0003_ffff);
			3: return {16'($urandom_range(16'hffff)), 16'h0000} + $urandom_range(2) - 1;
			4: return $urandom_range(1) ? 32'h7fff_0000 + $urandom() % 32'h10000
				: 32'h8000_0000 + $urandom() % 32'h10000;
			default: return {8'($urandom_range(8'hff)), 24'h0} ^ $urandom_range(16'hffff);
		endcase
	endfunction

	initial begin
		logic [31:0] edge_vals[12];
		int          wait_cycles;
		edge_vals = '{32'h0000_0000, 32'h0000_0001, 32'h0000_ffff, 32'h0001_0000,
			32'hffff_ffff, 32'hffff_0000, 32'hfffe_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0001, 32'h0000_8000, 32'hffff_8000};
		arst_n = 1'b0;
		start = 1'b0;
		x_coord = '0;
		y_coord = '0;
		beat_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, negative floor, top-of-range wrap, half cells.
		for (int i = 0; i < 12; i++)
			send_point(edge_vals[i], edge_vals[(i * 5 + 3) % 12], 1'b0);
		for (int i = 0; i < 8; i++)
			send_point(edge_vals[7 + (i % 2)], edge_vals[i], 1'b0);

		// Random: idling mixed in, then a long burst with no idling, then idling again with a drain pause.
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			send_point(pick_coord(), pick_coord(), i >= 200 && i < 500);
			if (i == 800) begin
				start <= 1'b0;
				@(posedge clk);
				while (pending_count != 0) @(posedge clk);
			end
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (pending_count != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		$display("covered %0d points, %0d noise values checked, incl. edges and wraps",
			beat_count, result_count);
		if (fail_count == 0 && pending_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#2ms;
		$display("testbench: done, errors");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pn2d_pkg.sv
hdl/perlin_noise_2d.sv
sim/noise_checker.sv
sim/testbench.sv
